FILE: hw/rtl/rpp_pkg.sv
package rpp_pkg;

    localparam int PIX_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int MODE_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_PASS     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_RED_ONLY = 4'd1;
    localparam logic [MODE_W-1:0] MODE_GRAY     = 4'd2;
    localparam logic [MODE_W-1:0] MODE_BW       = 4'd3;
    localparam logic [MODE_W-1:0] MODE_BRIGHT   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_CONTRAST = 4'd5;
    localparam logic [MODE_W-1:0] MODE_PROTAN   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_TRITAN   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DEUTAN   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_ROTATE   = 4'd9;

    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BW_THRESHOLD  = 3'd3;

    localparam logic [MODE_W-1:0] RST_OP_MODE       = MODE_PASS;
    localparam logic [GAIN_W-1:0] RST_BRIGHT_GAIN   = 16'd256;
    localparam logic [GAIN_W-1:0] RST_CONTRAST_GAIN = 16'd256;
    localparam logic [PIX_W-1:0]  RST_BW_THRESHOLD  = 8'd170;

    typedef struct packed {
        logic [MODE_W-1:0] op_mode;
        logic [GAIN_W-1:0] bright_gain;
        logic [GAIN_W-1:0] contrast_gain;
        logic [PIX_W-1:0]  bw_threshold;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } t_pixel;

endpackage

FILE: hw/rtl/rgb_pixel_point_operations_top.sv
// RGB pixel point-operation unit.
// Request channel: drive the pixel on i_red_in, i_green_in, i_blue_in and
// i_last_pixel_in with start high; the request is taken at a rising edge where
// start is high and busy is low. A new request may be taken every cycle.
// Result channel: o_done is high for exactly one cycle with the processed pixel
// on o_red_out, o_green_out, o_blue_out and o_last_pixel_out. The receiver
// cannot stall; a result must be captured in its strobe cycle.
// A request goes through the input register and the result register to o_done.
// Throughput: 1 pixel per clock; one combinational pass with three multipliers
// per gain mode (8x16 bright, 9x17 signed contrast) between the two registers.
// Configuration: i_cfg_we with i_cfg_idx (0 op_mode, 1 bright_gain,
// 2 contrast_gain, 3 bw_threshold) and i_cfg_data; write only while idle.
// Other indexes are ignored.
// Reset (i_rst_n low, synchronous): cfg registers go to defaults, the pipeline
// is emptied and busy is held high until the cycle after reset is released.
module rgb_pixel_point_operations_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rpp_pkg::PIX_W-1:0]      i_red_in,
    input  logic [rpp_pkg::PIX_W-1:0]      i_green_in,
    input  logic [rpp_pkg::PIX_W-1:0]      i_blue_in,
    input  logic                          i_last_pixel_in,
    output logic                          o_done,
    output logic [rpp_pkg::PIX_W-1:0]      o_red_out,
    output logic [rpp_pkg::PIX_W-1:0]      o_green_out,
    output logic [rpp_pkg::PIX_W-1:0]      o_blue_out,
    output logic                          o_last_pixel_out,
    input  logic                          i_cfg_we,
    input  logic [rpp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rpp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rpp_pkg::*;

    t_cfg   cfg;
    t_pixel in_px;
    t_pixel out_px;
    logic   req_acc;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy    = r_busy;
    assign req_acc = start && !r_busy;

    assign in_px.red   = i_red_in;
    assign in_px.green = i_green_in;
    assign in_px.blue  = i_blue_in;
    assign in_px.last  = i_last_pixel_in;

    rpp_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rpp_pixel_op u_pixel_op (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_vld   (req_acc),
        .i_px    (in_px),
        .o_vld   (o_done),
        .o_px    (out_px)
    );

    assign o_red_out        = out_px.red;
    assign o_green_out      = out_px.green;
    assign o_blue_out       = out_px.blue;
    assign o_last_pixel_out = out_px.last;

`ifndef SYNTHESIS
    a_req_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("request did not produce a result two cycles later");
    a_done_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without a matching request");
    a_last_copied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_last_pixel_out == $past(i_last_pixel_in, 2)))
        else $error("last pixel mark not carried through");
`endif

endmodule

FILE: hw/rtl/rpp_cfg_regs.sv
module rpp_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rpp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rpp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rpp_pkg::t_cfg                 o_cfg
);
    import rpp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.op_mode       <= RST_OP_MODE;
            r_cfg.bright_gain   <= RST_BRIGHT_GAIN;
            r_cfg.contrast_gain <= RST_CONTRAST_GAIN;
            r_cfg.bw_threshold  <= RST_BW_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OP_MODE:       r_cfg.op_mode       <= i_cfg_data[MODE_W-1:0];
                REG_BRIGHT_GAIN:   r_cfg.bright_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_CONTRAST_GAIN: r_cfg.contrast_gain <= i_cfg_data[GAIN_W-1:0];
                REG_BW_THRESHOLD:  r_cfg.bw_threshold  <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/rpp_pixel_op.sv
module rpp_pixel_op (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rpp_pkg::t_cfg   i_cfg,
    input  logic            i_vld,
    input  rpp_pkg::t_pixel i_px,
    output logic            o_vld,
    output rpp_pkg::t_pixel o_px
);
    import rpp_pkg::*;

    logic   r_in_vld;
    t_pixel r_in_px;
    logic   r_out_vld;
    t_pixel r_out_px;
    t_pixel n_out_px;

    logic [PIX_W+1:0]   sum;
    logic [PIX_W+1:0]   thr_x3;
    logic [PIX_W+12:0]  gray_prod;
    logic [PIX_W-1:0]   gray;
    logic               is_red;
    logic               is_green;
    logic               is_blue;
    logic               is_yellow;

    function automatic logic [PIX_W-1:0] bright_one(
        input logic [PIX_W-1:0]  c,
        input logic [GAIN_W-1:0] gain
    );
        logic [PIX_W+GAIN_W-1:0] p;
        p = c * gain;
        if (|p[PIX_W+GAIN_W-1:2*PIX_W]) begin
            return 8'd255;
        end
        return p[2*PIX_W-1:PIX_W];
    endfunction

    function automatic logic [PIX_W-1:0] contrast_one(
        input logic [PIX_W-1:0]  c,
        input logic [GAIN_W-1:0] gain
    );
        logic signed [PIX_W:0]          d;
        logic signed [PIX_W+GAIN_W+1:0] p;
        logic signed [GAIN_W+1:0]       q;
        d = $signed({1'b0, c}) - 9'sd128;
        p = d * $signed({1'b0, gain});
        q = p[PIX_W+GAIN_W+1:PIX_W] + 18'sd128;
        if (q < 18'sd0) begin
            return 8'd0;
        end
        if (q > 18'sd255) begin
            return 8'd255;
        end
        return q[PIX_W-1:0];
    endfunction

    always_comb begin
        sum       = {2'b00, r_in_px.red} + {2'b00, r_in_px.green} + {2'b00, r_in_px.blue};
        thr_x3    = {2'b00, i_cfg.bw_threshold} + {1'b0, i_cfg.bw_threshold, 1'b0};
        // floor(sum/3) as sum*683 >> 11, exact for sum <= 765
        gray_prod = {11'd0, sum} * 21'd683;
        gray      = gray_prod[PIX_W+10:11];
        is_red    = (r_in_px.red == 8'd255) && (r_in_px.green == 8'd0)
                    && (r_in_px.blue == 8'd0);
        is_green  = (r_in_px.red == 8'd0) && (r_in_px.green == 8'd255)
                    && (r_in_px.blue == 8'd0);
        is_blue   = (r_in_px.red == 8'd0) && (r_in_px.green == 8'd0)
                    && (r_in_px.blue == 8'd255);
        is_yellow = (r_in_px.red == 8'd255) && (r_in_px.green == 8'd255)
                    && (r_in_px.blue == 8'd0);

        n_out_px = r_in_px;
        case (i_cfg.op_mode)
            MODE_RED_ONLY: begin
                n_out_px.green = 8'd0;
                n_out_px.blue  = 8'd0;
            end
            MODE_GRAY: begin
                n_out_px.red   = gray;
                n_out_px.green = gray;
                n_out_px.blue  = gray;
            end
            MODE_BW: begin
                n_out_px.red   = (sum >= thr_x3) ? 8'd255 : 8'd0;
                n_out_px.green = (sum >= thr_x3) ? 8'd255 : 8'd0;
                n_out_px.blue  = (sum >= thr_x3) ? 8'd255 : 8'd0;
            end
            MODE_BRIGHT: begin
                n_out_px.red   = bright_one(r_in_px.red, i_cfg.bright_gain);
                n_out_px.green = bright_one(r_in_px.green, i_cfg.bright_gain);
                n_out_px.blue  = bright_one(r_in_px.blue, i_cfg.bright_gain);
            end
            MODE_CONTRAST: begin
                n_out_px.red   = contrast_one(r_in_px.red, i_cfg.contrast_gain);
                n_out_px.green = contrast_one(r_in_px.green, i_cfg.contrast_gain);
                n_out_px.blue  = contrast_one(r_in_px.blue, i_cfg.contrast_gain);
            end
            MODE_PROTAN: begin
                if (is_red) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd107, 8'd92, 8'd11};
                end else if (is_blue) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd0, 8'd56, 8'd253};
                end else if (is_green) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd254, 8'd237, 8'd1};
                end
            end
            MODE_TRITAN: begin
                if (is_red) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd255, 8'd0, 8'd78};
                end else if (is_blue) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd0, 8'd98, 8'd137};
                end else if (is_green) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd121, 8'd233, 8'd255};
                end
            end
            MODE_DEUTAN: begin
                if (is_red) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd165, 8'd139, 8'd0};
                end else if (is_blue) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd0, 8'd86, 8'd253};
                end else if (is_green) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd241, 8'd209, 8'd49};
                end
            end
            MODE_ROTATE: begin
                if (is_red) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd0, 8'd255, 8'd0};
                end else if (is_green) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd0, 8'd0, 8'd255};
                end else if (is_blue) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd255, 8'd0, 8'd0};
                end else if (is_yellow) begin
                    {n_out_px.red, n_out_px.green, n_out_px.blue} = {8'd102, 8'd204, 8'd255};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= i_vld;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_px  <= i_px;
        r_out_px <= n_out_px;
    end

    assign o_vld = r_out_vld;
    assign o_px  = r_out_px;

`ifndef SYNTHESIS
    a_gray_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_cfg.op_mode == MODE_GRAY) |->
        (r_out_px.red == r_out_px.green && r_out_px.green == r_out_px.blue))
        else $error("gray result components differ");
    a_bw_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_cfg.op_mode == MODE_BW) |->
        ((r_out_px.red == 8'd0 || r_out_px.red == 8'd255)
         && r_out_px.red == r_out_px.green && r_out_px.green == r_out_px.blue))
        else $error("black white result not pure black or white");
`endif

endmodule

FILE: tb/tb_rgb_pixel_point_operations_top.sv
module tb_rgb_pixel_point_operations_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rpp_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 4'd15;
    localparam int N_DIR       = 28;
    localparam int N_PHASES    = 34;
    localparam int PHASE_ITEMS = 50;
    localparam int QUIET_LIMIT = 1000;

    localparam logic [23:0] COL_RED    = {8'd255, 8'd0, 8'd0};
    localparam logic [23:0] COL_GREEN  = {8'd0, 8'd255, 8'd0};
    localparam logic [23:0] COL_BLUE   = {8'd0, 8'd0, 8'd255};
    localparam logic [23:0] COL_YELLOW = {8'd255, 8'd255, 8'd0};
    localparam logic [23:0] KEY_COLS [4] = '{COL_RED, COL_GREEN, COL_BLUE, COL_YELLOW};

    // color-blind remaps, indexed protan, tritan, deutan
    localparam logic [23:0] CB_RED [3] = '{
        {8'd107, 8'd92, 8'd11}, {8'd255, 8'd0, 8'd78}, {8'd165, 8'd139, 8'd0}};
    localparam logic [23:0] CB_BLUE [3] = '{
        {8'd0, 8'd56, 8'd253}, {8'd0, 8'd98, 8'd137}, {8'd0, 8'd86, 8'd253}};
    localparam logic [23:0] CB_GREEN [3] = '{
        {8'd254, 8'd237, 8'd1}, {8'd121, 8'd233, 8'd255}, {8'd241, 8'd209, 8'd49}};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [GAIN_W-1:0] bgain;
        logic [GAIN_W-1:0] cgain;
        logic [PIX_W-1:0]  thr;
        logic [PIX_W-1:0]  r, g, b;
        logic              l;
        logic              chk;
        logic [PIX_W-1:0]  er, eg, eb;
        logic              el;
    } t_dir_row;

    // mode, bright, contrast, threshold | pixel | typed-in check | expected pixel
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{MODE_PASS,     256,   256, 170,   0,   0,   0, 0, 1,   0,   0,   0, 0},
        '{MODE_PASS,     256,   256, 170, 255, 255, 255, 1, 1, 255, 255, 255, 1},
        '{MODE_RED_ONLY, 256,   256, 170, 255, 128, 127, 0, 1, 255,   0,   0, 0},
        '{MODE_GRAY,     256,   256, 170, 255, 255, 255, 1, 1, 255, 255, 255, 1},
        '{MODE_BW,       256,   256, 170, 170, 170, 170, 0, 1, 255, 255, 255, 0},
        '{MODE_BW,       256,   256, 170, 169, 170, 170, 0, 1,   0,   0,   0, 0},
        '{MODE_BW,       256,   256,   0,   0,   0,   0, 1, 1, 255, 255, 255, 1},
        '{MODE_BW,       256,   256, 255, 255, 255, 254, 0, 1,   0,   0,   0, 0},
        '{MODE_BRIGHT, 65535,   256, 255, 255,   1,   0, 0, 1, 255, 255,   0, 0},
        '{MODE_BRIGHT,     0,   256, 255, 255, 255, 255, 0, 1,   0,   0,   0, 0},
        '{MODE_BRIGHT,   384,   256, 255, 100, 171, 170, 1, 0,   0,   0,   0, 0},
        '{MODE_CONTRAST, 384,     0, 255,   0, 255, 128, 0, 1, 128, 128, 128, 0},
        '{MODE_CONTRAST, 384, 65535, 255,   0, 127, 129, 0, 1,   0,   0, 255, 0},
        '{MODE_CONTRAST, 384,   128, 255, 127,   0, 255, 1, 0,   0,   0,   0, 0},
        '{MODE_PROTAN,   384,   128, 255, 255,   0,   0, 0, 1, 107,  92,  11, 0},
        '{MODE_PROTAN,   384,   128, 255,   0, 255,   0, 0, 1, 254, 237,   1, 0},
        '{MODE_PROTAN,   384,   128, 255,   0,   0, 255, 0, 1,   0,  56, 253, 0},
        '{MODE_TRITAN,   384,   128, 255, 255,   0,   0, 0, 1, 255,   0,  78, 0},
        '{MODE_TRITAN,   384,   128, 255,   0, 255,   0, 0, 1, 121, 233, 255, 0},
        '{MODE_TRITAN,   384,   128, 255,   0,   0, 255, 1, 1,   0,  98, 137, 1},
        '{MODE_DEUTAN,   384,   128, 255, 255,   0,   0, 0, 1, 165, 139,   0, 0},
        '{MODE_DEUTAN,   384,   128, 255,   0, 255,   0, 0, 1, 241, 209,  49, 0},
        '{MODE_DEUTAN,   384,   128, 255,   0,   0, 255, 0, 1,   0,  86, 253, 0},
        '{MODE_ROTATE,   384,   128, 255, 255,   0,   0, 0, 1,   0, 255,   0, 0},
        '{MODE_ROTATE,   384,   128, 255,   0, 255,   0, 0, 1,   0,   0, 255, 0},
        '{MODE_ROTATE,   384,   128, 255,   0,   0, 255, 0, 1, 255,   0,   0, 0},
        '{MODE_ROTATE,   384,   128, 255, 255, 255,   0, 1, 1, 102, 204, 255, 1},
        '{MODE_UNUSED,   384,   128, 255,  12,  34,  56, 1, 1,  12,  34,  56, 1}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [PIX_W-1:0]      i_red_in = '0;
    logic [PIX_W-1:0]      i_green_in = '0;
    logic [PIX_W-1:0]      i_blue_in = '0;
    logic                  i_last_pixel_in = 1'b0;
    logic                  o_done;
    logic [PIX_W-1:0]      o_red_out;
    logic [PIX_W-1:0]      o_green_out;
    logic [PIX_W-1:0]      o_blue_out;
    logic                  o_last_pixel_out;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_cfg   cfg_now = '{RST_OP_MODE, RST_BRIGHT_GAIN, RST_CONTRAST_GAIN, RST_BW_THRESHOLD};
    t_pixel pending_pixels [$];
    int     mismatch_cnt = 0;
    int     quiet_cycles = 0;
    bit     calm = 1'b0;

    rgb_pixel_point_operations_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_red_in         (i_red_in),
        .i_green_in       (i_green_in),
        .i_blue_in        (i_blue_in),
        .i_last_pixel_in  (i_last_pixel_in),
        .o_done           (o_done),
        .o_red_out        (o_red_out),
        .o_green_out      (o_green_out),
        .o_blue_out       (o_blue_out),
        .o_last_pixel_out (o_last_pixel_out),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [PIX_W-1:0] bright_level(input logic [PIX_W-1:0] c);
        int v;
        v = (int'(c) * int'(cfg_now.bright_gain)) >>> 8;
        return (v > 255) ? 8'd255 : v[PIX_W-1:0];
    endfunction

    // floor toward minus infinity, then clamp
    function automatic logic [PIX_W-1:0] contrast_level(input logic [PIX_W-1:0] c);
        int v;
        v = ((int'(c) - 128) * int'(cfg_now.contrast_gain)) >>> 8;
        v = v + 128;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[PIX_W-1:0];
    endfunction

    function automatic t_pixel predict_pixel(input t_pixel p);
        logic [23:0] col;
        int          gray;
        int          k;
        t_pixel      q;
        col  = {p.red, p.green, p.blue};
        gray = (int'(p.red) + int'(p.green) + int'(p.blue)) / 3;
        case (cfg_now.op_mode) inside
            MODE_RED_ONLY: col = {p.red, 16'd0};
            MODE_GRAY:     col = {3{gray[PIX_W-1:0]}};
            MODE_BW:       col = (gray >= int'(cfg_now.bw_threshold)) ? 24'hFFFFFF : 24'h0;
            MODE_BRIGHT:   col = {bright_level(p.red), bright_level(p.green),
                                  bright_level(p.blue)};
            MODE_CONTRAST: col = {contrast_level(p.red), contrast_level(p.green),
                                  contrast_level(p.blue)};
            MODE_PROTAN, MODE_TRITAN, MODE_DEUTAN: begin
                k = int'(cfg_now.op_mode - MODE_PROTAN);
                case (col)
                    COL_RED:   col = CB_RED[k];
                    COL_BLUE:  col = CB_BLUE[k];
                    COL_GREEN: col = CB_GREEN[k];
                    default: ;
                endcase
            end
            MODE_ROTATE: begin
                case (col)
                    COL_RED:    col = COL_GREEN;
                    COL_GREEN:  col = COL_BLUE;
                    COL_BLUE:   col = COL_RED;
                    COL_YELLOW: col = {8'd102, 8'd204, 8'd255};
                    default: ;
                endcase
            end
            default: ;
        endcase
        q.red   = col[23:16];
        q.green = col[15:8];
        q.blue  = col[7:0];
        q.last  = p.last;
        return q;
    endfunction

    function automatic t_pixel pick_pixel();
        logic [23:0] col;
        t_pixel      p;
        case ($urandom_range(0, 9)) inside
            [0:3]:   col = KEY_COLS[$urandom_range(0, 3)];
            4:       col = KEY_COLS[$urandom_range(0, 3)] ^ (24'd1 << $urandom_range(0, 23));
            5:       col = {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
            default: col = 24'($urandom);
        endcase
        p.red   = col[23:16];
        p.green = col[15:8];
        p.blue  = col[7:0];
        p.last  = ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 16'd256;
            3:       return GAIN_W'($urandom_range(0, 511));
            4:       return GAIN_W'($urandom_range(0, 1023));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
        if (got !== want) log_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    task automatic wait_results_done();
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    // leaves i_cfg_we high; caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_OP_MODE:       cfg_now.op_mode       = data[MODE_W-1:0];
            REG_BRIGHT_GAIN:   cfg_now.bright_gain   = data[GAIN_W-1:0];
            REG_CONTRAST_GAIN: cfg_now.contrast_gain = data[GAIN_W-1:0];
            REG_BW_THRESHOLD:  cfg_now.bw_threshold  = data[PIX_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // upper data bits of the narrow registers carry noise that must be masked
    task automatic load_cfg(input t_cfg c, input bit every);
        if (every || c != cfg_now) begin
            wait_results_done();
            if (every || c.op_mode != cfg_now.op_mode)
                write_reg(REG_OP_MODE, {12'($urandom), c.op_mode});
            if (every || c.bright_gain != cfg_now.bright_gain)
                write_reg(REG_BRIGHT_GAIN, c.bright_gain);
            if (every || c.contrast_gain != cfg_now.contrast_gain)
                write_reg(REG_CONTRAST_GAIN, c.contrast_gain);
            if (every || c.bw_threshold != cfg_now.bw_threshold)
                write_reg(REG_BW_THRESHOLD, {8'($urandom), c.bw_threshold});
            if (every && $urandom_range(0, 1))
                write_reg(CFG_IDX_W'($urandom_range(REG_BW_THRESHOLD + 1,
                                                    (1 << CFG_IDX_W) - 1)),
                          CFG_DATA_W'($urandom));
            i_cfg_we <= 1'b0;
        end
    endtask

    task automatic drive_pixel(input t_pixel p, input bit typed, input t_pixel want);
        bit took;
        if (!calm && $urandom_range(0, 99) < 9) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_red_in        <= p.red;
        i_green_in      <= p.green;
        i_blue_in       <= p.blue;
        i_last_pixel_in <= p.last;
        do begin
            @(negedge i_clk);
            took = (busy === 1'b0);
            @(posedge i_clk);
        end while (!took);
        pending_pixels.insert(pending_pixels.size(), typed ? want : predict_pixel(p));
    endtask

    always @(negedge i_clk) begin : check_results
        t_pixel want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (o_done !== 1'b1) begin
                log_mismatch($sformatf("result strobe is %b", o_done));
            end else if (pending_pixels.size() == 0) begin
                log_mismatch("result with no request outstanding");
            end else begin
                want = pending_pixels.pop_front();
                check_field("red", want.red, o_red_out);
                check_field("green", want.green, o_green_out);
                check_field("blue", want.blue, o_blue_out);
                check_field("last", {7'd0, want.last}, {7'd0, o_last_pixel_out});
            end
        end
    end

    always @(negedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rgb_pixel_point_operations_top test failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row row;
        t_cfg     c;
        t_pixel   p;
        t_pixel   want;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk); while (busy !== 1'b0);
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            row  = DIR_ROWS[i];
            c    = '{row.mode, row.bgain, row.cgain, row.thr};
            p    = '{row.r, row.g, row.b, row.l};
            want = '{row.er, row.eg, row.eb, row.el};
            load_cfg(c, 1'b0);
            drive_pixel(p, row.chk, want);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            calm = (ph >= 20 && ph < 24);
            if (ph <= int'(MODE_UNUSED))
                c.op_mode = MODE_W'(ph);
            else if ($urandom_range(0, 3) == 0)
                c.op_mode = MODE_W'($urandom_range(MODE_PASS, MODE_UNUSED));
            else
                c.op_mode = MODE_W'($urandom_range(MODE_PASS, MODE_ROTATE));
            c.bright_gain   = pick_gain();
            c.contrast_gain = pick_gain();
            case ($urandom_range(0, 3))
                0:       c.bw_threshold = '0;
                1:       c.bw_threshold = '1;
                default: c.bw_threshold = PIX_W'($urandom);
            endcase
            load_cfg(c, 1'b1);
            repeat (PHASE_ITEMS) drive_pixel(pick_pixel(), 1'b0, want);
        end

        wait_results_done();
        repeat (4) @(posedge i_clk);
        if (pending_pixels.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
        if (mismatch_cnt == 0)
            $display("rgb_pixel_point_operations_top test passed");
        else
            $display("rgb_pixel_point_operations_top test failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/rpp_pkg.sv
hw/rtl/rpp_cfg_regs.sv
hw/rtl/rpp_pixel_op.sv
hw/rtl/rgb_pixel_point_operations_top.sv
tb/tb_rgb_pixel_point_operations_top.sv
